[rtl/core/pwmtc_pkg.sv]
package pwmtc_pkg;

  localparam int DATA_W    = 32;
  localparam int REG_W     = 16;
  localparam int PCT_W     = 7;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W    = REG_W + PCT_W;
  localparam int NEED_W    = DATA_W - REG_W + 1;

  localparam int DIV_STEPS = DATA_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // x / 100 == (x * RCP_100) >> RCP_SH for every x below 2**PROD_W
  localparam int               RCP_W   = 24;
  localparam int               RCP_SH  = 30;
  localparam logic [RCP_W-1:0] RCP_100 = 24'd10737419;

  localparam logic [REG_W-1:0]  REG_MAX   = 16'hFFFF;
  localparam logic [PCT_W-1:0]  PERCENT   = 7'd100;
  localparam logic [DATA_W-1:0] CLK_RESET = 32'd80000000;
  localparam logic [PCT_W-1:0]  MINP_RESET = 7'd0;
  localparam logic [PCT_W-1:0]  MAXP_RESET = 7'd100;

  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MINP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXP  = 2'd2;

  localparam logic [MODE_W-1:0] MODE_FREQ = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PCT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RAW  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ISSUE,
    ST_WAIT,
    ST_CHECK,
    ST_OUT
  } state_t;

  // datapath operation: divider operands on start, write-back target on wb
  typedef enum logic [3:0] {
    OP_P,
    OP_Q,
    OP_PCT,
    OP_LO,
    OP_HI,
    OP_RB1,
    OP_RB2,
    OP_DUTY,
    OP_FZERO,
    OP_P1,
    OP_ZRB
  } op_t;

  typedef struct packed {
    logic ready;
    logic load;
    logic start;
    logic wb;
    logic publish;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              value_zero;
    logic              p_one;
    logic              per_zero;
    logic              div_done;
    logic              out_busy;
  } sts_t;

  function automatic logic [REG_W-1:0] sat16(input logic [DATA_W-1:0] v);
    logic [REG_W-1:0] r;
    r = (v > DATA_W'(REG_MAX)) ? REG_MAX : v[REG_W-1:0];
    return r;
  endfunction

endpackage

[rtl/core/pwmtc_div.sv]
module pwmtc_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [pwmtc_pkg::DATA_W-1:0] num,
  input  logic [pwmtc_pkg::DATA_W-1:0] den,
  output logic                         done,
  output logic [pwmtc_pkg::DATA_W-1:0] quo
);
  import pwmtc_pkg::*;

  logic [DATA_W-1:0]    rem_r, rem_nxt;
  logic [DATA_W-1:0]    quo_r, quo_nxt;
  logic [DATA_W-1:0]    den_r, den_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;

  logic [DATA_W:0]   t1, t2;
  logic              ge1, ge2;
  logic [DATA_W-1:0] rem1, rem2;

  // two restoring steps per cycle
  always_comb begin
    t1   = {rem_r, quo_r[DATA_W-1]};
    ge1  = t1 >= {1'b0, den_r};
    rem1 = ge1 ? DATA_W'(t1 - {1'b0, den_r}) : t1[DATA_W-1:0];
    t2   = {rem1, quo_r[DATA_W-2]};
    ge2  = t2 >= {1'b0, den_r};
    rem2 = ge2 ? DATA_W'(t2 - {1'b0, den_r}) : t2[DATA_W-1:0];
  end

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = num;
      den_nxt  = den;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = rem2;
      quo_nxt = {quo_r[DATA_W-3:0], ge1, ge2};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

[rtl/core/pwmtc_ctrl.sv]
module pwmtc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  pwmtc_pkg::sts_t sts,
  output pwmtc_pkg::cmd_t cmd
);
  import pwmtc_pkg::*;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        case (sts.mode)
          MODE_FREQ: begin
            if (sts.value_zero) begin
              state_nxt = ST_CHECK;
            end else if (sts.p_one) begin
              op_nxt    = OP_Q;
              state_nxt = ST_ISSUE;
            end else begin
              op_nxt    = OP_P;
              state_nxt = ST_ISSUE;
            end
          end
          MODE_PCT: begin
            op_nxt    = OP_PCT;
            state_nxt = ST_ISSUE;
          end
          MODE_RAW: begin
            op_nxt    = OP_LO;
            state_nxt = ST_ISSUE;
          end
          default: state_nxt = ST_CHECK;
        endcase
      end
      ST_ISSUE: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (sts.div_done) begin
          case (op_r)
            OP_P: begin
              op_nxt    = OP_Q;
              state_nxt = ST_ISSUE;
            end
            OP_LO: begin
              op_nxt    = OP_HI;
              state_nxt = ST_ISSUE;
            end
            OP_RB1: begin
              op_nxt    = OP_RB2;
              state_nxt = ST_ISSUE;
            end
            OP_RB2: begin
              op_nxt    = OP_DUTY;
              state_nxt = ST_ISSUE;
            end
            OP_DUTY: state_nxt = ST_OUT;
            default: state_nxt = ST_CHECK;
          endcase
        end
      end
      ST_CHECK: begin
        if (sts.per_zero) begin
          state_nxt = ST_OUT;
        end else begin
          op_nxt    = OP_RB1;
          state_nxt = ST_ISSUE;
        end
      end
      ST_OUT: begin
        if (!sts.out_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.op    = op_r;
    case (state_r)
      ST_IDLE: begin
        cmd.ready = 1'b1;
        cmd.load  = in_valid;
      end
      ST_DECODE: begin
        if (sts.mode == MODE_FREQ && sts.value_zero) begin
          cmd.wb = 1'b1;
          cmd.op = OP_FZERO;
        end else if (sts.mode == MODE_FREQ && sts.p_one) begin
          cmd.wb = 1'b1;
          cmd.op = OP_P1;
        end
      end
      ST_ISSUE: cmd.start = 1'b1;
      ST_WAIT:  cmd.wb    = sts.div_done;
      ST_CHECK: begin
        if (sts.per_zero) begin
          cmd.wb = 1'b1;
          cmd.op = OP_ZRB;
        end
      end
      ST_OUT:  cmd.publish = !sts.out_busy;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_P;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

endmodule

[rtl/core/pwmtc_dp.sv]
module pwmtc_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pwmtc_pkg::cmd_t                 cmd,
  output pwmtc_pkg::sts_t                 sts,
  input  logic                            cfg_we,
  input  logic [pwmtc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pwmtc_pkg::DATA_W-1:0]    cfg_wdata,
  input  logic [pwmtc_pkg::MODE_W-1:0]    in_mode,
  input  logic [pwmtc_pkg::DATA_W-1:0]    in_value,
  input  logic                            in_restart,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [pwmtc_pkg::REG_W-1:0]     out_prescaler,
  output logic [pwmtc_pkg::REG_W-1:0]     out_period,
  output logic [pwmtc_pkg::REG_W-1:0]     out_compare,
  output logic                            out_counter_restart,
  output logic [pwmtc_pkg::DATA_W-1:0]    out_frequency_readback,
  output logic [pwmtc_pkg::PCT_W-1:0]     out_duty_readback
);
  import pwmtc_pkg::*;

  logic [DATA_W-1:0] clk_hz_r, clk_hz_nxt;
  logic [PCT_W-1:0]  minp_r, minp_nxt;
  logic [PCT_W-1:0]  maxp_r, maxp_nxt;

  logic [MODE_W-1:0] mode_r;
  logic [DATA_W-1:0] value_r;
  logic              restart_r;

  logic [REG_W-1:0]  pscl_r, pscl_nxt;
  logic [REG_W-1:0]  per_r, per_nxt;
  logic [REG_W-1:0]  cmp_r, cmp_nxt;
  logic [DATA_W-1:0] tmp_r, tmp_nxt;
  logic [DATA_W-1:0] freq_r, freq_nxt;
  logic [PCT_W-1:0]  duty_r, duty_nxt;

  logic              ovld_r, ovld_nxt;
  logic [REG_W-1:0]  opscl_r, oper_r, ocmp_r;
  logic              orst_r;
  logic [DATA_W-1:0] ofreq_r;
  logic [PCT_W-1:0]  oduty_r;

  logic [NEED_W-1:0]       need;
  logic [REG_W-1:0]        per_m1;
  logic [DATA_W-1:0]       d1;
  logic [PCT_W-1:0]        dcl;
  logic [PROD_W-1:0]       prod_pct, prod_lo, prod_hi, prod_duty;
  logic [DATA_W+NEED_W-1:0] prod_pf;
  logic [DATA_W-1:0]       div_num, div_den, quo;
  logic                    div_done;
  logic [DATA_W-1:0]       t1, t2;

  logic                    cdiv;
  logic                    cdone_r;
  logic [PROD_W-1:0]       cnum_r;
  logic [PROD_W+RCP_W-1:0] cprod;
  logic [DATA_W-1:0]       res;

  assign need   = NEED_W'(clk_hz_r[DATA_W-1:REG_W]) + 1'b1;
  assign per_m1 = (per_r == '0) ? '0 : per_r - 1'b1;

  // percent clamp: min first, then max
  always_comb begin
    d1  = (value_r < DATA_W'(minp_r)) ? DATA_W'(minp_r) : value_r;
    dcl = (d1 > DATA_W'(maxp_r)) ? maxp_r : d1[PCT_W-1:0];
  end

  assign prod_pct  = per_m1 * dcl;
  assign prod_lo   = per_r * minp_r;
  assign prod_hi   = per_m1 * maxp_r;
  assign prod_duty = cmp_r * PERCENT;
  assign prod_pf   = tmp_r[NEED_W-1:0] * value_r;

  always_comb begin
    div_num = clk_hz_r;
    div_den = DATA_W'(PERCENT);
    case (cmd.op)
      OP_P: begin
        div_num = value_r + DATA_W'(need) - 1'b1;
        div_den = value_r;
      end
      OP_Q: begin
        div_num = clk_hz_r;
        div_den = prod_pf[DATA_W-1:0];
      end
      OP_PCT:  div_num = DATA_W'(prod_pct);
      OP_LO:   div_num = DATA_W'(prod_lo);
      OP_HI:   div_num = DATA_W'(prod_hi);
      OP_RB1: begin
        div_num = clk_hz_r;
        div_den = DATA_W'(per_r);
      end
      OP_RB2: begin
        div_num = tmp_r;
        div_den = DATA_W'(pscl_r) + 1'b1;
      end
      OP_DUTY: begin
        div_num = DATA_W'(prod_duty);
        div_den = DATA_W'(per_r);
      end
      default: begin
        div_num = clk_hz_r;
        div_den = DATA_W'(PERCENT);
      end
    endcase
  end

  // division by 100: reciprocal multiply on the registered dividend
  assign cdiv  = (cmd.op == OP_PCT) | (cmd.op == OP_LO) | (cmd.op == OP_HI);
  assign cprod = cnum_r * RCP_100;
  assign res   = cdiv ? DATA_W'(cprod[PROD_W+RCP_W-1:RCP_SH]) : quo;

  pwmtc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start & ~cdiv),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  // raw clamp: lo held in tmp_r, hi is the fresh quotient
  always_comb begin
    t1 = (value_r < tmp_r) ? tmp_r : value_r;
    t2 = (t1 > res) ? res : t1;
  end

  always_comb begin
    pscl_nxt = pscl_r;
    per_nxt  = per_r;
    cmp_nxt  = cmp_r;
    tmp_nxt  = tmp_r;
    freq_nxt = freq_r;
    duty_nxt = duty_r;
    if (cmd.wb) begin
      case (cmd.op)
        OP_P:  tmp_nxt = res;
        OP_P1: tmp_nxt = DATA_W'(1);
        OP_Q: begin
          pscl_nxt = sat16(tmp_r - 1'b1);
          per_nxt  = sat16(res);
        end
        OP_FZERO: begin
          pscl_nxt = REG_MAX;
          per_nxt  = REG_MAX;
        end
        OP_PCT:  cmp_nxt  = sat16(res);
        OP_LO:   tmp_nxt  = res;
        OP_HI:   cmp_nxt  = sat16(t2);
        OP_RB1:  tmp_nxt  = res;
        OP_RB2:  freq_nxt = res;
        OP_DUTY: duty_nxt = (res > DATA_W'(PERCENT)) ? PERCENT : res[PCT_W-1:0];
        OP_ZRB: begin
          freq_nxt = '0;
          duty_nxt = '0;
        end
        default: tmp_nxt = tmp_r;
      endcase
    end
  end

  always_comb begin
    clk_hz_nxt = clk_hz_r;
    minp_nxt   = minp_r;
    maxp_nxt   = maxp_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_CLOCK: clk_hz_nxt = cfg_wdata;
        CFG_MINP:  minp_nxt   = cfg_wdata[PCT_W-1:0];
        CFG_MAXP:  maxp_nxt   = cfg_wdata[PCT_W-1:0];
        default:   clk_hz_nxt = clk_hz_r;
      endcase
    end
  end

  assign ovld_nxt = cmd.publish | (ovld_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_hz_r <= CLK_RESET;
      minp_r   <= MINP_RESET;
      maxp_r   <= MAXP_RESET;
      pscl_r   <= '0;
      per_r    <= REG_MAX;
      cmp_r    <= '0;
      ovld_r   <= 1'b0;
      cdone_r  <= 1'b0;
    end else begin
      clk_hz_r <= clk_hz_nxt;
      minp_r   <= minp_nxt;
      maxp_r   <= maxp_nxt;
      pscl_r   <= pscl_nxt;
      per_r    <= per_nxt;
      cmp_r    <= cmp_nxt;
      ovld_r   <= ovld_nxt;
      cdone_r  <= cmd.start & cdiv;
    end
  end

  always_ff @(posedge clk) begin
    tmp_r  <= tmp_nxt;
    freq_r <= freq_nxt;
    duty_r <= duty_nxt;
    if (cmd.start & cdiv) begin
      cnum_r <= div_num[PROD_W-1:0];
    end
    if (cmd.load) begin
      mode_r    <= in_mode;
      value_r   <= in_value;
      restart_r <= in_restart;
    end
    if (cmd.publish) begin
      opscl_r <= pscl_r;
      oper_r  <= per_r;
      ocmp_r  <= cmp_r;
      orst_r  <= (mode_r == MODE_FREQ) & restart_r;
      ofreq_r <= freq_r;
      oduty_r <= duty_r;
    end
  end

  always_comb begin
    sts.mode       = mode_r;
    sts.value_zero = (value_r == '0);
    sts.p_one      = (value_r >= DATA_W'(need));
    sts.per_zero   = (per_r == '0);
    sts.div_done   = cdiv ? cdone_r : div_done;
    sts.out_busy   = ovld_r & out_stall;
  end

  assign out_valid              = ovld_r;
  assign out_prescaler          = opscl_r;
  assign out_period             = oper_r;
  assign out_compare            = ocmp_r;
  assign out_counter_restart    = orst_r;
  assign out_frequency_readback = ofreq_r;
  assign out_duty_readback      = oduty_r;

endmodule

[rtl/core/pwm_timing_calculator_unit.sv]
// PWM timing calculator for one channel. Each command (set frequency, set duty
// percent, set raw compare ticks) updates the stored prescaler and period
// (frequency) or the stored compare value (percent, raw ticks) and returns one
// result with the stored registers, a counter restart flag and frequency and
// duty readbacks. Divisions by a variable run on one shared divider that
// resolves two quotient bits per cycle; divisions by 100 use a reciprocal
// multiply. A frequency command runs five divides on the divider, or four when
// the divider comes out as one; a zero frequency and a command with an unknown
// mode run three, a percent command one reciprocal multiply and three divides,
// and a raw command two reciprocal multiplies and three divides. A command that
// leaves a zero period skips the readback divides. One command is in work at a
// time; the finished result sits in an output register so the next command
// may be accepted while it waits to be taken. Configuration writes take
// effect at once and are meant for idle periods only.
module pwm_timing_calculator_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [pwmtc_pkg::MODE_W-1:0]    in_mode,
  input  logic [pwmtc_pkg::DATA_W-1:0]    in_value,
  input  logic                            in_restart,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [pwmtc_pkg::REG_W-1:0]     out_prescaler,
  output logic [pwmtc_pkg::REG_W-1:0]     out_period,
  output logic [pwmtc_pkg::REG_W-1:0]     out_compare,
  output logic                            out_counter_restart,
  output logic [pwmtc_pkg::DATA_W-1:0]    out_frequency_readback,
  output logic [pwmtc_pkg::PCT_W-1:0]     out_duty_readback,
  input  logic                            cfg_we,
  input  logic [pwmtc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pwmtc_pkg::DATA_W-1:0]    cfg_wdata
);
  import pwmtc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pwmtc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd)
  );

  pwmtc_dp u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .sts                    (sts),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_mode                (in_mode),
    .in_value               (in_value),
    .in_restart             (in_restart),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_prescaler          (out_prescaler),
    .out_period             (out_period),
    .out_compare            (out_compare),
    .out_counter_restart    (out_counter_restart),
    .out_frequency_readback (out_frequency_readback),
    .out_duty_readback      (out_duty_readback)
  );

  assign in_stall = ~cmd.ready;

endmodule

[rtl/core/pwmtc_checker.sv]
module pwmtc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [pwmtc_pkg::REG_W-1:0]     out_period,
  input logic [pwmtc_pkg::REG_W-1:0]     out_compare,
  input logic [pwmtc_pkg::DATA_W-1:0]    out_frequency_readback,
  input logic [pwmtc_pkg::PCT_W-1:0]     out_duty_readback
);
  import pwmtc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_compare))
    else $error("stalled result dropped or changed");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again while a command is in work");

  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_duty_readback <= PERCENT)
    else $error("duty readback above 100");

  a_zero_period: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_period == '0 |->
      out_frequency_readback == '0 && out_duty_readback == '0)
    else $error("nonzero readback with zero period");

endmodule

bind pwm_timing_calculator_unit pwmtc_checker u_pwmtc_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .in_valid               (in_valid),
  .in_stall               (in_stall),
  .out_valid              (out_valid),
  .out_stall              (out_stall),
  .out_period             (out_period),
  .out_compare            (out_compare),
  .out_frequency_readback (out_frequency_readback),
  .out_duty_readback      (out_duty_readback)
);

[tb/sv/pwm_timing_checker.sv]
module pwm_timing_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [pwmtc_pkg::MODE_W-1:0]    in_mode,
  input  logic [pwmtc_pkg::DATA_W-1:0]    in_value,
  input  logic                            in_restart,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [pwmtc_pkg::REG_W-1:0]     out_prescaler,
  input  logic [pwmtc_pkg::REG_W-1:0]     out_period,
  input  logic [pwmtc_pkg::REG_W-1:0]     out_compare,
  input  logic                            out_counter_restart,
  input  logic [pwmtc_pkg::DATA_W-1:0]    out_frequency_readback,
  input  logic [pwmtc_pkg::PCT_W-1:0]     out_duty_readback,
  input  logic                            cfg_we,
  input  logic [pwmtc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pwmtc_pkg::DATA_W-1:0]    cfg_wdata,
  output int                              fail_count,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import pwmtc_pkg::*;

  typedef struct packed {
    logic [REG_W-1:0]  prescaler;
    logic [REG_W-1:0]  period;
    logic [REG_W-1:0]  compare;
    logic              restart;
    logic [DATA_W-1:0] frequency;
    logic [PCT_W-1:0]  duty;
  } timing_result_t;

  logic [DATA_W-1:0] clock_hz;
  logic [PCT_W-1:0]  min_pct;
  logic [PCT_W-1:0]  max_pct;
  logic [REG_W-1:0]  prescale_q;
  logic [REG_W-1:0]  period_q;
  logic [REG_W-1:0]  compare_q;

  timing_result_t expected_q[$];

  function automatic logic [REG_W-1:0] clip16(input logic [63:0] v);
    return (v > 64'hFFFF) ? REG_MAX : v[REG_W-1:0];
  endfunction

  // updates the shadow registers and returns the result this command produces
  function automatic timing_result_t timing_update(input logic [MODE_W-1:0] mode,
                                                   input logic [DATA_W-1:0] value,
                                                   input logic restart);
    logic [63:0] need, div, quo, per_m1, lo, hi, ticks, pct, duty;
    timing_result_t r;
    per_m1 = (period_q == 0) ? 64'd0 : 64'(period_q) - 64'd1;
    case (mode)
      MODE_FREQ: begin
        if (value == 0) begin
          prescale_q = REG_MAX;
          period_q   = REG_MAX;
        end else begin
          need = 64'(clock_hz) / 64'h10000 + 64'd1;
          div  = (need + 64'(value) - 64'd1) / 64'(value);
          if (div == 0) div = 64'd1;
          quo = 64'(clock_hz) / (div * 64'(value));
          prescale_q = clip16(div - 64'd1);
          period_q   = clip16(quo);
        end
      end
      MODE_PCT: begin
        pct = 64'(value);
        if (pct < 64'(min_pct)) pct = 64'(min_pct);
        if (pct > 64'(max_pct)) pct = 64'(max_pct);
        compare_q = clip16(per_m1 * pct / 64'd100);
      end
      MODE_RAW: begin
        lo = 64'(period_q) * 64'(min_pct) / 64'd100;
        hi = per_m1 * 64'(max_pct) / 64'd100;
        ticks = 64'(value);
        if (ticks < lo) ticks = lo;
        if (ticks > hi) ticks = hi;
        compare_q = clip16(ticks);
      end
      default: ;
    endcase
    r.prescaler = prescale_q;
    r.period    = period_q;
    r.compare   = compare_q;
    r.restart   = (mode == MODE_FREQ) && restart;
    r.frequency = '0;
    r.duty      = '0;
    if (period_q != 0) begin
      r.frequency = DATA_W'(64'(clock_hz) / 64'(period_q) / (64'(prescale_q) + 64'd1));
      duty = 64'd100 * 64'(compare_q) / 64'(period_q);
      r.duty = (duty > 64'd100) ? PERCENT : duty[PCT_W-1:0];
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    timing_result_t want;
    if (!rst_n) begin
      clock_hz   = CLK_RESET;
      min_pct    = MINP_RESET;
      max_pct    = MAXP_RESET;
      prescale_q = '0;
      period_q   = REG_MAX;
      compare_q  = '0;
      fail_count = 0;
      expected_q.delete();
      pending <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual prescaler %0d period %0d",
                   $time, out_prescaler, out_period);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("prescaler", DATA_W'(want.prescaler), DATA_W'(out_prescaler));
          check_field("period", DATA_W'(want.period), DATA_W'(out_period));
          check_field("compare", DATA_W'(want.compare), DATA_W'(out_compare));
          check_field("counter_restart", DATA_W'(want.restart),
                      DATA_W'(out_counter_restart));
          check_field("frequency_readback", want.frequency, out_frequency_readback);
          check_field("duty_readback", DATA_W'(want.duty), DATA_W'(out_duty_readback));
        end
      end
      if (in_valid && !in_stall)
        expected_q.push_back(timing_update(in_mode, in_value, in_restart));
      if (cfg_we) begin
        case (cfg_index)
          CFG_CLOCK: clock_hz = cfg_wdata;
          CFG_MINP:  min_pct  = cfg_wdata[PCT_W-1:0];
          CFG_MAXP:  max_pct  = cfg_wdata[PCT_W-1:0];
          default: ;
        endcase
      end
      pending <= expected_q.size();
    end
  end

endmodule

[tb/sv/tb_pwm_timing_calculator_unit.sv]
module tb_pwm_timing_calculator_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import pwmtc_pkg::*;

  localparam logic [MODE_W-1:0] MODE_HOLD = 2'd3;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [MODE_W-1:0]    in_mode = MODE_FREQ;
  logic [DATA_W-1:0]    in_value = '0;
  logic                 in_restart = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [REG_W-1:0]     out_prescaler;
  logic [REG_W-1:0]     out_period;
  logic [REG_W-1:0]     out_compare;
  logic                 out_counter_restart;
  logic [DATA_W-1:0]    out_frequency_readback;
  logic [PCT_W-1:0]     out_duty_readback;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_CLOCK;
  logic [DATA_W-1:0]    cfg_wdata = '0;

  int                   fail_count;
  int                   pending;
  bit                   calm = 1'b0;
  logic [DATA_W-1:0]    cur_clock = CLK_RESET;

  pwm_timing_calculator_unit DUT (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_mode                (in_mode),
    .in_value               (in_value),
    .in_restart             (in_restart),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_prescaler          (out_prescaler),
    .out_period             (out_period),
    .out_compare            (out_compare),
    .out_counter_restart    (out_counter_restart),
    .out_frequency_readback (out_frequency_readback),
    .out_duty_readback      (out_duty_readback),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata)
  );

  pwm_timing_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_cmd(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] value,
                          input logic restart);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_mode    <= mode;
    in_value   <= value;
    in_restart <= restart;
    do @(posedge clk); while (in_stall);
  endtask

  // hold off the sender until every outstanding result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_config(input logic [DATA_W-1:0] clock, input logic [PCT_W-1:0] lo_pct,
                            input logic [PCT_W-1:0] hi_pct);
    drain();
    cur_clock = clock;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CLOCK;
    cfg_wdata <= clock;
    @(posedge clk);
    cfg_index <= CFG_MINP;
    cfg_wdata <= DATA_W'(lo_pct);
    @(posedge clk);
    cfg_index <= CFG_MAXP;
    cfg_wdata <= DATA_W'(hi_pct);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_config();
    logic [DATA_W-1:0] clock;
    int lo, hi;
    case ($urandom_range(0, 5))
      0: clock = 32'd1;
      1: clock = 32'hFFFF_FFFF;
      2: clock = CLK_RESET;
      3: clock = $urandom_range(1000, 200_000_000);
      default: clock = $urandom();
    endcase
    if (clock == 0) clock = 32'd1;
    case ($urandom_range(0, 3))
      0: begin lo = 0; hi = 100; end
      1: begin lo = $urandom_range(0, 100); hi = $urandom_range(lo, 100); end
      2: begin lo = $urandom_range(0, 127); hi = $urandom_range(0, 127); end
      default: begin lo = $urandom_range(0, 50); hi = $urandom_range(50, 100); end
    endcase
    set_config(clock, PCT_W'(lo), PCT_W'(hi));
  endtask

  task automatic random_cmd();
    int pick;
    logic [MODE_W-1:0] mode;
    logic [DATA_W-1:0] value;
    pick = $urandom_range(0, 19);
    if (pick < 7)       mode = MODE_FREQ;
    else if (pick < 13) mode = MODE_PCT;
    else if (pick < 18) mode = MODE_RAW;
    else                mode = MODE_HOLD;
    pick = $urandom_range(0, 7);
    case (mode)
      MODE_FREQ: begin
        case (pick)
          0: value = '0;
          1: value = $urandom_range(1, 100);
          2: value = $urandom_range(1, 100_000);
          3: value = cur_clock >> $urandom_range(0, 31);
          4: value = cur_clock / $urandom_range(1, 65536) + $urandom_range(0, 2);
          default: value = $urandom();
        endcase
      end
      MODE_PCT: begin
        if (pick < 6)       value = $urandom_range(0, 127);
        else if (pick == 6) value = $urandom();
        else                value = $urandom_range(0, 1) ? 32'd100 : 32'd0;
      end
      default: begin
        if (pick < 6) value = $urandom_range(0, 70_000);
        else          value = $urandom();
      end
    endcase
    send_cmd(mode, value, 1'($urandom_range(0, 1)));
  endtask

  initial begin : result_sink
    int n;
    @(posedge clk);
    forever begin
      n = calm ? 0 : $urandom_range(0, 3);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_cmd(MODE_PCT, 32'd50, 1'b0);
    send_cmd(MODE_RAW, 32'd0, 1'b1);
    send_cmd(MODE_RAW, 32'hFFFF_FFFF, 1'b0);
    send_cmd(MODE_HOLD, 32'hFFFF_FFFF, 1'b1);
    send_cmd(MODE_FREQ, 32'd0, 1'b1);
    send_cmd(MODE_PCT, 32'd100, 1'b0);
    send_cmd(MODE_FREQ, 32'd1, 1'b0);
    send_cmd(MODE_FREQ, 32'd20_000, 1'b1);
    send_cmd(MODE_PCT, 32'd0, 1'b0);
    send_cmd(MODE_PCT, 32'hFFFF_FFFF, 1'b0);
    send_cmd(MODE_FREQ, CLK_RESET, 1'b0);
    send_cmd(MODE_PCT, 32'd100, 1'b0);
    send_cmd(MODE_FREQ, 32'hFFFF_FFFF, 1'b1);
    send_cmd(MODE_PCT, 32'd50, 1'b0);
    send_cmd(MODE_RAW, 32'd1000, 1'b0);

    // crossed bounds: max wins
    set_config(CLK_RESET, 7'd80, 7'd20);
    send_cmd(MODE_FREQ, 32'd1000, 1'b0);
    send_cmd(MODE_PCT, 32'd50, 1'b0);
    send_cmd(MODE_RAW, 32'd0, 1'b0);
    send_cmd(MODE_RAW, 32'hFFFF_FFFF, 1'b0);

    // bounds above 100, largest clock
    set_config(32'hFFFF_FFFF, 7'd127, 7'd127);
    send_cmd(MODE_FREQ, 32'd1, 1'b1);
    send_cmd(MODE_PCT, 32'd0, 1'b0);
    send_cmd(MODE_RAW, 32'd0, 1'b0);
    send_cmd(MODE_RAW, 32'hFFFF_FFFF, 1'b0);

    set_config(32'd1, 7'd0, 7'd0);
    send_cmd(MODE_FREQ, 32'd1, 1'b0);
    send_cmd(MODE_PCT, 32'd100, 1'b0);
    send_cmd(MODE_RAW, 32'd5, 1'b0);

    for (int phase = 0; phase < 10; phase++) begin
      random_config();
      calm = (phase % 4 == 3);
      repeat (125) random_cmd();
    end
    calm = 1'b0;

    drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
